FILE: rtl/lru_name_address_cache_unit_defines.svh
// Assertion macros shared by the name/address cache RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef LRU_NAME_ADDRESS_CACHE_UNIT_DEFINES_SVH
`define LRU_NAME_ADDRESS_CACHE_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define LNAC_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define LNAC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define LNAC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/lnac_pkg.sv
// Shared types and constants for the name/address cache.
// Depends on nothing; used by the store, the controller and the top level.
package lnac_pkg;

	localparam int CACHE_ENTRIES_DEF = 10;

	localparam int ADDR_W  = 32;
	localparam int KEY_W   = 64;
	localparam int STAMP_W = 32;

	localparam int S_TDATA_W = 256;
	localparam int M_TDATA_W = 160;

	// Operation codes carried in the slave tuser bit.
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// Payload of one cache entry.
	typedef struct packed {
		logic [KEY_W-1:0]  dotted_key;
		logic [KEY_W-1:0]  name_key;
		logic [ADDR_W-1:0] address;
	} entry_t;

	// Write request from the controller to the entry store.
	typedef struct packed {
		logic               data_we;
		logic               stamp_we;
		entry_t             data;
		logic [STAMP_W-1:0] stamp;
	} wr_req_t;

endpackage

FILE: rtl/lnac_store.sv
// Entry store: payload memory, last-used stamp memory and per-slot valid bits.
// Depends on lnac_pkg; both memories have a registered read.
module lnac_store #(
	parameter int ENTRIES = lnac_pkg::CACHE_ENTRIES_DEF,
	parameter int IDX_W   = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [IDX_W-1:0]              rd_idx,
	input  logic [IDX_W-1:0]              wr_idx,
	input  lnac_pkg::wr_req_t             wr,
	output lnac_pkg::entry_t              rd_entry,
	output logic [lnac_pkg::STAMP_W-1:0]  rd_stamp,
	output logic [ENTRIES-1:0]            valid
);

	lnac_pkg::entry_t             data_mem [ENTRIES];
	logic [lnac_pkg::STAMP_W-1:0] stamp_mem [ENTRIES];
	lnac_pkg::entry_t             rd_entry_q;
	logic [lnac_pkg::STAMP_W-1:0] rd_stamp_q;
	logic [ENTRIES-1:0]           valid_q;

	// Payload memory with registered read.
	always_ff @(posedge clk) begin
		if (wr.data_we) begin
			data_mem[wr_idx] <= wr.data;
		end
		if (rd_en) begin
			rd_entry_q <= data_mem[rd_idx];
		end
	end

	// Stamp memory with registered read.
	always_ff @(posedge clk) begin
		if (wr.stamp_we) begin
			stamp_mem[wr_idx] <= wr.stamp;
		end
		if (rd_en) begin
			rd_stamp_q <= stamp_mem[rd_idx];
		end
	end

	// A slot becomes valid on its first payload write and stays valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.data_we) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	assign rd_entry = rd_entry_q;
	assign rd_stamp = rd_stamp_q;
	assign valid    = valid_q;

endmodule

FILE: rtl/lnac_ctrl.sv
// Sequencer of the name/address cache: handshakes, memory scan, result register.
// Depends on lnac_pkg and the assertion macros; drives the ports of lnac_store.
`include "lru_name_address_cache_unit_defines.svh"

module lnac_ctrl #(
	parameter int ENTRIES = lnac_pkg::CACHE_ENTRIES_DEF,
	parameter int IDX_W   = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [lnac_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic [0:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [lnac_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic [1:0]                      m_tuser,
	output logic                            rd_en,
	output logic [IDX_W-1:0]                rd_idx,
	output logic [IDX_W-1:0]                wr_idx,
	output lnac_pkg::wr_req_t               wr,
	input  lnac_pkg::entry_t                rd_entry,
	input  logic [lnac_pkg::STAMP_W-1:0]    rd_stamp,
	input  logic [ENTRIES-1:0]              valid
);

	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t                        state_q;
	logic [CNT_W-1:0]              count_q;
	logic [CNT_W-1:0]              issue_q;
	logic                          rd_vld_s1;
	logic [IDX_W-1:0]              idx_s1;

	logic                          op_q;
	logic [lnac_pkg::STAMP_W-1:0]  time_q;
	lnac_pkg::entry_t              item_q;
	logic [lnac_pkg::KEY_W-1:0]    host_q;
	logic [lnac_pkg::STAMP_W-1:0]  best_stamp_q;
	logic [IDX_W-1:0]              best_idx_q;

	logic                          res_hit_q;
	logic                          res_ev_q;
	lnac_pkg::entry_t              res_entry_q;

	logic                          m_tvalid_q;
	lnac_pkg::entry_t              m_entry_q;
	logic [1:0]                    m_tuser_q;

	logic                          accept;
	logic                          in_op;
	logic [lnac_pkg::STAMP_W-1:0]  in_time;
	lnac_pkg::entry_t              in_entry;
	logic [lnac_pkg::KEY_W-1:0]    in_host;
	logic                          full;
	logic [IDX_W-1:0]              free_idx;
	logic                          fast_insert;
	logic                          key_match;
	logic                          last_s1;
	logic                          older;
	logic [IDX_W-1:0]              victim_idx;
	logic                          scan_hit;
	logic                          scan_end;
	logic                          out_free;

	// Lowest slot whose valid bit is clear.
	function automatic logic [IDX_W-1:0] lowest_free(input logic [ENTRIES-1:0] v);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!v[i]) begin
				idx = IDX_W'(i);
			end
		end
		return idx;
	endfunction

	// Input transaction fields.
	assign in_op             = s_tuser[0];
	assign in_time           = s_tdata[31:0];
	assign in_entry.address  = s_tdata[63:32];
	assign in_entry.name_key = s_tdata[127:64];
	assign in_entry.dotted_key = s_tdata[191:128];
	assign in_host           = s_tdata[255:192];

	assign s_tready    = (state_q == S_IDLE);
	assign accept      = s_tvalid && s_tready;
	assign full        = (count_q == CNT_W'(ENTRIES));
	assign free_idx    = lowest_free(valid);
	assign fast_insert = accept && (in_op == lnac_pkg::OP_INSERT) && !full;

	// Scan read port: one slot per cycle until every slot has been issued or the scan ends.
	assign rd_en  = (state_q == S_SCAN) && (issue_q < CNT_W'(ENTRIES));
	assign rd_idx = issue_q[IDX_W-1:0];

	// Compare stage on the registered read data.
	assign key_match = valid[idx_s1] &&
		((rd_entry.name_key == host_q) || (rd_entry.dotted_key == host_q));
	assign last_s1    = (idx_s1 == LAST_IDX);
	assign older      = (idx_s1 == '0) || (rd_stamp < best_stamp_q);
	assign victim_idx = older ? idx_s1 : best_idx_q;
	assign scan_hit   = (state_q == S_SCAN) && rd_vld_s1 &&
		(op_q == lnac_pkg::OP_LOOKUP) && key_match;
	assign scan_end   = (state_q == S_SCAN) && rd_vld_s1 && (scan_hit || last_s1);

	assign out_free = !m_tvalid_q || m_tready;

	// Memory write request: free-slot insert, victim replacement or stamp refresh.
	always_comb begin
		wr.data_we  = 1'b0;
		wr.stamp_we = 1'b0;
		wr.data     = item_q;
		wr.stamp    = time_q;
		wr_idx      = idx_s1;
		if (fast_insert) begin
			wr.data_we  = 1'b1;
			wr.stamp_we = 1'b1;
			wr.data     = in_entry;
			wr.stamp    = in_time;
			wr_idx      = free_idx;
		end else if (scan_end && (op_q == lnac_pkg::OP_INSERT)) begin
			wr.data_we  = 1'b1;
			wr.stamp_we = 1'b1;
			wr_idx      = victim_idx;
		end else if (scan_hit) begin
			wr.stamp_we = 1'b1;
		end
	end

	// Control state: sequencer, scan counters, fill count and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			issue_q    <= '0;
			rd_vld_s1  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if ((state_q == S_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						issue_q   <= '0;
						rd_vld_s1 <= 1'b0;
						if (fast_insert) begin
							count_q <= count_q + CNT_W'(1);
							state_q <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					rd_vld_s1 <= rd_en && !scan_end;
					if (rd_en) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					if (scan_end) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item, scan pipeline and result payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= in_op;
			time_q <= in_time;
			item_q <= in_entry;
			host_q <= in_host;
		end
		if (state_q == S_SCAN) begin
			idx_s1 <= rd_idx;
		end
		if ((state_q == S_SCAN) && rd_vld_s1 && older) begin
			best_stamp_q <= rd_stamp;
			best_idx_q   <= idx_s1;
		end
		if (fast_insert) begin
			res_hit_q   <= 1'b1;
			res_ev_q    <= 1'b0;
			res_entry_q <= in_entry;
		end else if (scan_end) begin
			if (op_q == lnac_pkg::OP_INSERT) begin
				res_hit_q   <= 1'b1;
				res_ev_q    <= 1'b1;
				res_entry_q <= item_q;
			end else if (scan_hit) begin
				res_hit_q   <= 1'b1;
				res_ev_q    <= 1'b0;
				res_entry_q <= rd_entry;
			end else begin
				res_hit_q   <= 1'b0;
				res_ev_q    <= 1'b0;
				res_entry_q <= '0;
			end
		end
		if ((state_q == S_DONE) && out_free) begin
			m_entry_q <= res_entry_q;
			m_tuser_q <= {res_ev_q, res_hit_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {m_entry_q.dotted_key, m_entry_q.name_key, m_entry_q.address};
	assign m_tuser  = m_tuser_q;

	// The fill count tracks the valid bits exactly.
	`LNAC_ASSERT_ALWAYS(a_count_matches_valid, clk, arst_n, $countones(valid) == count_q, "fill count disagrees with valid bits")
	// A result only enters the output register from the completion state.
	`LNAC_ASSERT_SAME(a_result_from_done, clk, arst_n, $rose(m_tvalid_q), $past(state_q == S_DONE), "output loaded outside completion")
	// An insert into a table with a free slot completes without a scan.
	`LNAC_ASSERT_NEXT(a_fast_insert_done, clk, arst_n, fast_insert, (state_q == S_DONE) && res_hit_q && !res_ev_q, "free-slot insert did not complete")
	// A lookup scan never rewrites entry payloads.
	`LNAC_ASSERT_SAME(a_lookup_no_payload_write, clk, arst_n, (state_q == S_SCAN) && (op_q == lnac_pkg::OP_LOOKUP), !wr.data_we, "lookup wrote entry payload")

endmodule

FILE: rtl/lru_name_address_cache_unit.sv
// An insert into a table with a free slot skips the scan and goes from acceptance straight to the
// completion state; a full-table insert or a lookup scans the slots in order, a lookup stopping at its first hit.
// One transaction at a time: the next is accepted once the result reaches the output register,
// which waits while m_tready holds back an earlier result.
// Reset clears the valid bits, fill count and handshake state at once; entry memories are not
// cleared, and a slot's contents only count once it has been written.
module lru_name_address_cache_unit #(
	parameter int CACHE_ENTRIES = lnac_pkg::CACHE_ENTRIES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// time_now[31:0], address[63:32], name_key[127:64], dotted_key[191:128], host_key[255:192]
	input  logic [lnac_pkg::S_TDATA_W-1:0]  s_tdata,
	// op[0]
	input  logic [0:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// found_address[31:0], found_name_key[95:32], found_dotted_key[159:96]
	output logic [lnac_pkg::M_TDATA_W-1:0]  m_tdata,
	// hit[0], evicted[1]
	output logic [1:0]                      m_tuser
);

	localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

	logic                          rd_en;
	logic [IDX_W-1:0]              rd_idx;
	logic [IDX_W-1:0]              wr_idx;
	lnac_pkg::wr_req_t             wr;
	lnac_pkg::entry_t              rd_entry;
	logic [lnac_pkg::STAMP_W-1:0]  rd_stamp;
	logic [CACHE_ENTRIES-1:0]      valid;

	// Sequencer and result register.
	lnac_ctrl #(
		.ENTRIES (CACHE_ENTRIES),
		.IDX_W   (IDX_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.rd_en    (rd_en),
		.rd_idx   (rd_idx),
		.wr_idx   (wr_idx),
		.wr       (wr),
		.rd_entry (rd_entry),
		.rd_stamp (rd_stamp),
		.valid    (valid)
	);

	// Entry memories and valid bits.
	lnac_store #(
		.ENTRIES (CACHE_ENTRIES),
		.IDX_W   (IDX_W)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_idx   (rd_idx),
		.wr_idx   (wr_idx),
		.wr       (wr),
		.rd_entry (rd_entry),
		.rd_stamp (rd_stamp),
		.valid    (valid)
	);

endmodule

FILE: dv/lru_name_address_cache_unit_tb.sv
// Self-checking testbench for the LRU name/address cache unit.
// Depends on lnac_pkg and lru_name_address_cache_unit; drives stream transactions and
// checks every result against a cycle-free model of the cache table.
`timescale 1ns / 100ps

module lru_name_address_cache_unit_tb;

	localparam int NUM_SLOTS    = lnac_pkg::CACHE_ENTRIES_DEF;
	localparam int RANDOM_REQS  = 550;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int IDLE_PERCENT = 29;
	localparam int MAX_PRINTS   = 40;

	// One request to the cache, as queued for the driver.
	typedef struct {
		logic                         op;
		logic [lnac_pkg::STAMP_W-1:0] time_now;
		logic [lnac_pkg::ADDR_W-1:0]  address;
		logic [lnac_pkg::KEY_W-1:0]   name_key;
		logic [lnac_pkg::KEY_W-1:0]   dotted_key;
		logic [lnac_pkg::KEY_W-1:0]   host_key;
		bit                           drain_first;
	} cache_req_t;

	// One expected answer from the cache.
	typedef struct {
		logic                        hit;
		logic                        evicted;
		logic [lnac_pkg::ADDR_W-1:0] address;
		logic [lnac_pkg::KEY_W-1:0]  name_key;
		logic [lnac_pkg::KEY_W-1:0]  dotted_key;
	} cache_rsp_t;

	logic                           clk      = 1'b0;
	logic                           arst_n   = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [lnac_pkg::S_TDATA_W-1:0] s_tdata  = '0;
	logic [0:0]                     s_tuser  = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [lnac_pkg::M_TDATA_W-1:0] m_tdata;
	logic [1:0]                     m_tuser;

	cache_req_t pending_reqs[$];
	cache_rsp_t expected_results[$];
	logic [lnac_pkg::KEY_W-1:0] known_keys[$];
	cache_req_t cur_req;
	bit req_taken = 1'b0;
	int sent_count = 0;
	int total_reqs = 0;
	int error_count = 0;
	int cycle_count = 0;
	logic [lnac_pkg::STAMP_W-1:0] stamp_clock = '0;

	// Shadow copy of the cache table.
	bit                           shadow_used[NUM_SLOTS];
	logic [lnac_pkg::ADDR_W-1:0]  shadow_address[NUM_SLOTS];
	logic [lnac_pkg::KEY_W-1:0]   shadow_name[NUM_SLOTS];
	logic [lnac_pkg::KEY_W-1:0]   shadow_dotted[NUM_SLOTS];
	logic [lnac_pkg::STAMP_W-1:0] shadow_stamp[NUM_SLOTS];
	int                           shadow_fill = 0;

	// Idling is switched off for a stretch in the middle of the run.
	wire calm = (sent_count >= 250) && (sent_count < 350);

	lru_name_address_cache_unit #(
		.CACHE_ENTRIES(NUM_SLOTS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
	end

	// Prints one line per mismatch, up to a cap, and counts every one.
	task automatic report_mismatch(input string what, input logic [lnac_pkg::KEY_W-1:0] got,
			input logic [lnac_pkg::KEY_W-1:0] want);
		if (error_count < MAX_PRINTS) begin
			$display("%0t ns: mismatch in %s: got %h, expected %h", $time, what, got, want);
		end
		error_count++;
	endtask

	// Applies one request to the shadow table and queues the answer it must give.
	task automatic predict_cache_step(input cache_req_t req);
		cache_rsp_t rsp;
		int victim;
		int slot;
		rsp = '{hit: 1'b0, evicted: 1'b0, address: '0, name_key: '0, dotted_key: '0};
		slot = -1;
		if (req.op == lnac_pkg::OP_INSERT) begin
			// A full table first gives up its oldest entry, lowest slot on a tie.
			if (shadow_fill >= NUM_SLOTS) begin
				victim = -1;
				for (int i = 0; i < NUM_SLOTS; i++) begin
					if (shadow_used[i] && (victim < 0 || shadow_stamp[i] < shadow_stamp[victim])) begin
						victim = i;
					end
				end
				if (victim >= 0) begin
					shadow_used[victim] = 1'b0;
					shadow_fill--;
					rsp.evicted = 1'b1;
				end
			end
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (!shadow_used[i] && slot < 0) begin
					slot = i;
				end
			end
			if (slot >= 0) begin
				shadow_used[slot]    = 1'b1;
				shadow_address[slot] = req.address;
				shadow_name[slot]    = req.name_key;
				shadow_dotted[slot]  = req.dotted_key;
				shadow_stamp[slot]   = req.time_now;
				shadow_fill++;
			end
		end else begin
			// The lowest valid slot matching either key wins and is refreshed.
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (slot < 0 && shadow_used[i] &&
						(shadow_name[i] == req.host_key || shadow_dotted[i] == req.host_key)) begin
					slot = i;
				end
			end
			if (slot >= 0) begin
				shadow_stamp[slot] = req.time_now;
			end
		end
		if (slot >= 0) begin
			rsp.hit        = 1'b1;
			rsp.address    = shadow_address[slot];
			rsp.name_key   = shadow_name[slot];
			rsp.dotted_key = shadow_dotted[slot];
		end
		expected_results.push_back(rsp);
	endtask

	function automatic logic [lnac_pkg::KEY_W-1:0] rand_key();
		return {$urandom, $urandom};
	endfunction

	task automatic queue_insert(input logic [lnac_pkg::STAMP_W-1:0] now,
			input logic [lnac_pkg::ADDR_W-1:0] addr, input logic [lnac_pkg::KEY_W-1:0] name,
			input logic [lnac_pkg::KEY_W-1:0] dotted, input bit drain);
		cache_req_t req;
		req = '{op: lnac_pkg::OP_INSERT, time_now: now, address: addr, name_key: name,
			dotted_key: dotted, host_key: rand_key(), drain_first: drain};
		pending_reqs.push_back(req);
		known_keys.push_back(name);
		known_keys.push_back(dotted);
		while (known_keys.size() > 40) begin
			void'(known_keys.pop_front());
		end
	endtask

	task automatic queue_lookup(input logic [lnac_pkg::STAMP_W-1:0] now,
			input logic [lnac_pkg::KEY_W-1:0] host, input bit drain);
		cache_req_t req;
		req = '{op: lnac_pkg::OP_LOOKUP, time_now: now, address: $urandom, name_key: rand_key(),
			dotted_key: rand_key(), host_key: host, drain_first: drain};
		pending_reqs.push_back(req);
	endtask

	// Picks a key for an insert or a lookup: reused, tiny or fully random.
	function automatic logic [lnac_pkg::KEY_W-1:0] pick_key(input int reuse_percent);
		int roll;
		roll = $urandom_range(99);
		if (roll < reuse_percent && known_keys.size() != 0) begin
			return known_keys[$urandom_range(known_keys.size() - 1)];
		end else if (roll < reuse_percent + 12) begin
			return lnac_pkg::KEY_W'($urandom_range(15));
		end
		return rand_key();
	endfunction

	// Driver: takes a transaction at the rising edge and feeds the shadow table.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			predict_cache_step(cur_req);
			req_taken = 1'b1;
			sent_count++;
		end
	end

	// Driver: presents the next request or idles at the falling edge.
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || req_taken)) begin
			req_taken = 1'b0;
			if (pending_reqs.size() != 0 &&
					!(pending_reqs[0].drain_first && expected_results.size() != 0) &&
					(calm || $urandom_range(99) >= IDLE_PERCENT)) begin
				cur_req = pending_reqs.pop_front();
				s_tdata <= {cur_req.host_key, cur_req.dotted_key, cur_req.name_key,
					cur_req.address, cur_req.time_now};
				s_tuser <= cur_req.op;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: random back-pressure on the result side.
	always @(negedge clk) begin
		if (arst_n) begin
			m_tready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// Monitor: compares each result transaction with the oldest expectation.
	always @(posedge clk) begin
		cache_rsp_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", lnac_pkg::KEY_W'(m_tdata[31:0]), '0);
			end else begin
				want = expected_results.pop_front();
				if (m_tuser[0] !== want.hit) begin
					report_mismatch("hit", lnac_pkg::KEY_W'(m_tuser[0]),
						lnac_pkg::KEY_W'(want.hit));
				end
				if (m_tuser[1] !== want.evicted) begin
					report_mismatch("evicted", lnac_pkg::KEY_W'(m_tuser[1]),
						lnac_pkg::KEY_W'(want.evicted));
				end
				if (m_tdata[31:0] !== want.address) begin
					report_mismatch("found_address", lnac_pkg::KEY_W'(m_tdata[31:0]),
						lnac_pkg::KEY_W'(want.address));
				end
				if (m_tdata[95:32] !== want.name_key) begin
					report_mismatch("found_name_key", m_tdata[95:32], want.name_key);
				end
				if (m_tdata[159:96] !== want.dotted_key) begin
					report_mismatch("found_dotted_key", m_tdata[159:96], want.dotted_key);
				end
			end
		end
	end

	// Watchdog for a hung handshake.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
		end
		$display("lru_name_address_cache_unit_tb: FAIL");
		$finish;
	end

	// Stimulus and end of run.
	initial begin
		logic [lnac_pkg::STAMP_W-1:0] now;
		int roll;

		for (int i = 0; i < NUM_SLOTS; i++) begin
			shadow_used[i] = 1'b0;
		end

		// Directed part: empty miss, field extremes, both key matches, ties and eviction.
		queue_lookup(32'd10, '0, 1'b0);
		queue_insert('0, '0, '0, '1, 1'b0);
		queue_insert('1, '1, '1, '0, 1'b0);
		queue_lookup(32'd20, '1, 1'b0);
		queue_lookup(32'd30, '0, 1'b0);
		queue_lookup(32'd40, 64'h5555_5555_5555_5555, 1'b0);
		for (int k = 2; k < NUM_SLOTS; k++) begin
			queue_insert(32'd100, 32'hC0A8_0000 | k, 64'h1000 + k, 64'hA5A5_A5A5_0000_0000 ^ k,
				1'b0);
		end
		queue_insert(32'd100, 32'h0A00_0001, 64'h2001, 64'h3001, 1'b0);
		queue_insert(32'd150, 32'h0A00_0002, 64'h2002, 64'h3002, 1'b0);
		// Duplicate name key: the lower slot keeps answering.
		queue_insert(32'd160, 32'h0A00_0003, 64'h1005, 64'h3003, 1'b0);
		queue_lookup(32'd170, 64'h1005, 1'b0);
		queue_lookup(32'd180, '1, 1'b0);
		// A refresh to stamp zero makes that entry the next victim.
		queue_lookup(32'd0, 64'h1004, 1'b0);
		queue_insert(32'd190, 32'h0A00_0004, 64'h2004, 64'h3004, 1'b0);
		queue_lookup(32'd200, 64'h1004, 1'b0);
		queue_lookup(32'd210, '0, 1'b0);

		// Random part: mostly rising stamps with ties, some fully random ones.
		stamp_clock = 32'd1000;
		for (int n = 0; n < RANDOM_REQS; n++) begin
			roll = $urandom_range(9);
			if (roll == 0) begin
				now = $urandom;
			end else if (roll == 1) begin
				now = stamp_clock;
			end else begin
				stamp_clock = stamp_clock + $urandom_range(1, 20);
				now = stamp_clock;
			end
			if ($urandom_range(1) == 0) begin
				queue_insert(now, $urandom, pick_key(10), pick_key(10), (n % 110) == 0);
			end else begin
				queue_lookup(now, pick_key(60), (n % 110) == 0);
			end
		end
		total_reqs = pending_reqs.size();

		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		while (sent_count < total_reqs || expected_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (NUM_SLOTS + 4) @(negedge clk);

		if (expected_results.size() != 0) begin
			report_mismatch("missing results", lnac_pkg::KEY_W'(expected_results.size()), '0);
		end
		if (error_count == 0) begin
			$display("lru_name_address_cache_unit_tb: PASS");
		end else begin
			$display("lru_name_address_cache_unit_tb: FAIL");
		end
		$finish;
	end

endmodule
